// File: hdl/tmd_pkg.sv
// ----------------------------------------------------------------------------
// tmd_pkg
// shared types and key codes for the teleop motor drive
// ----------------------------------------------------------------------------
package tmd_pkg;

  // input word kinds
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // key bytes
  localparam logic [7:0] KEY_ESC     = 8'h1b;
  localparam logic [7:0] KEY_SPACE   = 8'h20;
  localparam logic [7:0] KEY_PLUS    = 8'h2b;
  localparam logic [7:0] KEY_MINUS   = 8'h2d;
  localparam logic [7:0] KEY_EQUAL   = 8'h3d;
  localparam logic [7:0] KEY_UNDER   = 8'h5f;
  localparam logic [7:0] KEY_UPPER_A = 8'h41;
  localparam logic [7:0] KEY_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] KEY_W       = 8'h77;
  localparam logic [7:0] KEY_S       = 8'h73;
  localparam logic [7:0] KEY_A       = 8'h61;
  localparam logic [7:0] KEY_D       = 8'h64;
  localparam logic [7:0] KEY_Q       = 8'h71;
  localparam logic [7:0] KEY_E       = 8'h65;
  localparam logic [7:0] KEY_X       = 8'h78;

  // side commands
  localparam logic signed [1:0] CMD_STOP = 2'sb00;
  localparam logic signed [1:0] CMD_FWD  = 2'sb01;
  localparam logic signed [1:0] CMD_REV  = 2'sb11;

  // register indexes
  localparam logic [7:0] REG_HOLD_TIMEOUT = 8'd0;
  localparam logic [7:0] REG_SPEED_STEP   = 8'd1;
  localparam logic [7:0] REG_SPEED_START  = 8'd2;

  // reset values of the registers, and the speed and idle limits
  localparam logic [15:0] HOLD_TIMEOUT_RST = 16'd120;
  localparam logic [7:0]  SPEED_STEP_RST   = 8'd10;
  localparam logic [7:0]  SPEED_START_RST  = 8'd255;
  localparam logic [7:0]  SPEED_MAX        = 8'd255;
  localparam logic [15:0] IDLE_MAX         = 16'hffff;

  typedef struct packed {
    logic        valid;
    logic [7:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [1:0] left_dir;
    logic signed [1:0] right_dir;
    logic [7:0]        speed;
    logic              auto_stopped;
    logic              halted;
  } tmd_state_t;

  typedef struct packed {
    logic              left_pin_a;
    logic              left_pin_b;
    logic [10:0]       left_duty;
    logic              right_pin_a;
    logic              right_pin_b;
    logic [10:0]       right_duty;
    logic signed [1:0] left_command;
    logic signed [1:0] right_command;
    logic [7:0]        speed_level;
    logic              auto_stopped;
    logic              halted;
  } tmd_out_t;

endpackage

// File: hdl/tmd_core.sv
// ----------------------------------------------------------------------------
// tmd_core
// key decode, speed and idle tracking, dead-man timeout, config registers
// ----------------------------------------------------------------------------
module tmd_core
  import tmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_key,
  output logic       res_valid,
  input  logic       res_ready,
  output tmd_state_t res
);

  logic [15:0]       hold_timeout;
  logic [7:0]        speed_step;
  logic [7:0]        speed_start;

  logic [7:0]        speed_reg;
  logic signed [1:0] left_dir_reg;
  logic signed [1:0] right_dir_reg;
  logic [15:0]       idle_count;
  logic              halt_flag;

  logic [7:0]        speed_next;
  logic signed [1:0] left_dir_next;
  logic signed [1:0] right_dir_next;
  logic [15:0]       idle_next;
  logic              halt_next;
  logic              autostop;
  logic [7:0]        key_fold;
  logic [8:0]        speed_sum;
  logic              accept;

  assign in_ready = !res_valid || res_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    key_fold       = in_key;
    speed_sum      = {1'b0, speed_reg} + {1'b0, speed_step};
    speed_next     = speed_reg;
    left_dir_next  = left_dir_reg;
    right_dir_next = right_dir_reg;
    idle_next      = idle_count;
    halt_next      = halt_flag;
    autostop       = 1'b0;
    if (in_key >= KEY_UPPER_A && in_key <= KEY_UPPER_Z) begin
      key_fold = in_key + CASE_OFFSET;
    end
    if (!halt_flag) begin
      if (in_op == OP_TICK) begin
        if (idle_count != IDLE_MAX) begin
          idle_next = idle_count + 16'd1;
        end
      end else begin
        case (key_fold)
          KEY_ESC: begin
            left_dir_next  = CMD_STOP;
            right_dir_next = CMD_STOP;
            halt_next      = 1'b1;
          end
          KEY_W, KEY_S, KEY_A, KEY_D, KEY_Q, KEY_E: begin
            speed_next = speed_start;
            idle_next  = '0;
            case (key_fold)
              KEY_W: begin
                left_dir_next  = CMD_FWD;
                right_dir_next = CMD_FWD;
              end
              KEY_S: begin
                left_dir_next  = CMD_REV;
                right_dir_next = CMD_REV;
              end
              KEY_A: begin
                left_dir_next  = CMD_REV;
                right_dir_next = CMD_FWD;
              end
              KEY_D: begin
                left_dir_next  = CMD_FWD;
                right_dir_next = CMD_REV;
              end
              KEY_Q: begin
                left_dir_next  = CMD_STOP;
                right_dir_next = CMD_FWD;
              end
              default: begin
                left_dir_next  = CMD_FWD;
                right_dir_next = CMD_STOP;
              end
            endcase
          end
          KEY_X, KEY_SPACE: begin
            left_dir_next  = CMD_STOP;
            right_dir_next = CMD_STOP;
          end
          KEY_PLUS, KEY_EQUAL: begin
            speed_next = speed_sum[8] ? SPEED_MAX : speed_sum[7:0];
          end
          KEY_MINUS, KEY_UNDER: begin
            speed_next = (speed_reg > speed_step) ? speed_reg - speed_step : 8'd0;
          end
          default: begin
          end
        endcase
      end
      // dead-man check after every word while not halted
      if (!halt_next && (left_dir_next != CMD_STOP || right_dir_next != CMD_STOP) &&
          idle_next > hold_timeout) begin
        left_dir_next  = CMD_STOP;
        right_dir_next = CMD_STOP;
        autostop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout  <= HOLD_TIMEOUT_RST;
      speed_step    <= SPEED_STEP_RST;
      speed_start   <= SPEED_START_RST;
      speed_reg     <= SPEED_START_RST;
      left_dir_reg  <= CMD_STOP;
      right_dir_reg <= CMD_STOP;
      idle_count    <= '0;
      halt_flag     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_HOLD_TIMEOUT: hold_timeout <= cfg.data;
          REG_SPEED_STEP:   speed_step   <= cfg.data[7:0];
          REG_SPEED_START:  speed_start  <= cfg.data[7:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        speed_reg     <= speed_next;
        left_dir_reg  <= left_dir_next;
        right_dir_reg <= right_dir_next;
        idle_count    <= idle_next;
        halt_flag     <= halt_next;
        res_valid     <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.left_dir     <= left_dir_next;
      res.right_dir    <= right_dir_next;
      res.speed        <= speed_next;
      res.auto_stopped <= autostop;
      res.halted       <= halt_next;
    end
  end

endmodule

// File: hdl/tmd_drive.sv
// ----------------------------------------------------------------------------
// tmd_drive
// h-bridge pin mapping and pwm duty lookup, output register
// ----------------------------------------------------------------------------
module tmd_drive
  import tmd_pkg::*;
#(
  parameter int DUTY_RANGE = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       res_valid,
  output logic       res_ready,
  input  tmd_state_t res,
  output logic       out_valid,
  input  logic       out_ready,
  output tmd_out_t   out
);

  logic [10:0] duty_lut [256];
  logic [10:0] duty;
  logic        accept;

  // speed*DUTY_RANGE/255, kept to the 11-bit field
  for (genvar i = 0; i < 256; i++) begin : g_lut
    assign duty_lut[i] = 11'((i * DUTY_RANGE) / 255);
  end

  assign duty      = duty_lut[res.speed];
  assign res_ready = !out_valid || out_ready;
  assign accept    = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out.left_pin_a    <= (res.left_dir == CMD_REV);
      out.left_pin_b    <= (res.left_dir == CMD_FWD);
      out.left_duty     <= (res.left_dir == CMD_STOP) ? 11'd0 : duty;
      out.right_pin_a   <= (res.right_dir == CMD_REV);
      out.right_pin_b   <= (res.right_dir == CMD_FWD);
      out.right_duty    <= (res.right_dir == CMD_STOP) ? 11'd0 : duty;
      out.left_command  <= res.left_dir;
      out.right_command <= res.right_dir;
      out.speed_level   <= res.speed;
      out.auto_stopped  <= res.auto_stopped;
      out.halted        <= res.halted;
    end
  end

endmodule

// File: hdl/teleop_motor_drive_with_deadman.sv
// ----------------------------------------------------------------------------
// teleop_motor_drive_with_deadman
// keyboard teleop for a two-motor h-bridge drive with an idle auto stop
// ----------------------------------------------------------------------------
// Each input word is a key byte (tuser 0) or a one-millisecond tick (tuser 1)
// and produces exactly one output word with the bridge pins, pwm duty,
// commands, speed and status. Keys w s a d q e (either case) set the side
// commands, restore the speed to speed_start and clear the idle count; x and
// space stop; + = and - _ step the speed with saturation; ESC stops and halts
// until reset. Ticks count idle time, and a moving drive whose idle count
// passes hold_timeout is stopped with auto_stopped set in that word. The path
// from input handshake to output valid has two registers: one for the key
// decode and state update, one for the pin mapping and the duty lookup
// (a constant 256-entry table of speed*DUTY_RANGE/255). One word is taken
// every cycle unless the output stalls; both stages keep moving while it is
// stalled as long as a stage ahead has room. Registers are written through
// the cfg port at any time, but only while no word is in flight do they take
// a clean effect; cfg_ready is always high and unknown indexes are dropped.
module teleop_motor_drive_with_deadman
  import tmd_pkg::*;
#(
  parameter int DUTY_RANGE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] left_pin_a, [1] left_pin_b, [12:2] left_duty, [13] right_pin_a,
  // [14] right_pin_b, [25:15] right_duty, [27:26] left_command,
  // [29:28] right_command, [37:30] speed_level, [38] auto_stopped, [39] halted
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_wr_t    cfg;
  tmd_state_t state_word;
  logic       state_valid;
  logic       state_ready;
  tmd_out_t   out_word;

  // config writes never back-pressure
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // stage one: decode and state
  tmd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_key    (s_axis_tdata),
    .res_valid (state_valid),
    .res_ready (state_ready),
    .res       (state_word)
  );

  // stage two: bridge pins and duty
  tmd_drive #(
    .DUTY_RANGE (DUTY_RANGE)
  ) u_drive (
    .clk       (clk),
    .rst       (rst),
    .res_valid (state_valid),
    .res_ready (state_ready),
    .res       (state_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out       (out_word)
  );

  // pack output word, first field lowest
  assign m_axis_tdata = {out_word.halted, out_word.auto_stopped, out_word.speed_level,
                         out_word.right_command, out_word.left_command,
                         out_word.right_duty, out_word.right_pin_b, out_word.right_pin_a,
                         out_word.left_duty, out_word.left_pin_b, out_word.left_pin_a};

endmodule

// File: hdl/tmd_checker.sv
// ----------------------------------------------------------------------------
// tmd_checker
// port-level checks for the teleop motor drive
// ----------------------------------------------------------------------------
module tmd_checker
  import tmd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // once halted, every later word stays halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[39] |=> !m_axis_tvalid || m_axis_tdata[39])
    else $error("halt flag dropped before reset");

  // stopped side has zero duty and pins follow the command
  a_bridge: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[1] == (m_axis_tdata[27:26] == CMD_FWD)) &&
      (m_axis_tdata[0] == (m_axis_tdata[27:26] == CMD_REV)) &&
      (m_axis_tdata[14] == (m_axis_tdata[29:28] == CMD_FWD)) &&
      (m_axis_tdata[13] == (m_axis_tdata[29:28] == CMD_REV)) &&
      (m_axis_tdata[27:26] != CMD_STOP || m_axis_tdata[12:2] == 11'd0) &&
      (m_axis_tdata[29:28] != CMD_STOP || m_axis_tdata[25:15] == 11'd0))
    else $error("bridge pins or duty disagree with command");

  // auto stop leaves both sides stopped and is never flagged when halted
  a_autostop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[38] |->
      m_axis_tdata[27:26] == CMD_STOP && m_axis_tdata[29:28] == CMD_STOP &&
      !m_axis_tdata[39])
    else $error("auto stop word shows motion or halt");

endmodule

bind teleop_motor_drive_with_deadman tmd_checker u_tmd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/tb_teleop_motor_drive_with_deadman.sv
// ----------------------------------------------------------------------------
// tb_teleop_motor_drive_with_deadman
// self-checking bench for the keyboard teleop drive with idle auto stop
// ----------------------------------------------------------------------------
// Key and tick words go in on the slave stream in random bursts while the
// master side stalls on its own pattern. Every accepted input word runs
// through a local model of the drive, and the expected output word is queued.
// Each output word is checked field by field against the oldest queued word.
// Directed tests cover the key map, case folding, speed saturation, the idle
// timeout on ticks and on keys, the timeout boundary and the ESC halt.
// Random phases run at several register settings before the ESC halt test.
// ----------------------------------------------------------------------------
module tb_teleop_motor_drive_with_deadman;
  import tmd_pkg::*;

  localparam int DUTY_RANGE    = 1024;
  localparam int LATENCY       = 2;
  localparam int SETTLE_CYCLES = LATENCY + 4;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int MAX_REPORTS   = 50;
  localparam int EDGE_HOLD     = 200;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] key_code
  logic        s_axis_tuser = 1'b0;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] left_pin_a, [1] left_pin_b, [12:2] left_duty, [13] right_pin_a,
  // [14] right_pin_b, [25:15] right_duty, [27:26] left_command,
  // [29:28] right_command, [37:30] speed_level, [38] auto_stopped, [39] halted
  logic [39:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [15:0] cfg_data = 16'd0;

  // local copy of the registers, starting at their reset values
  logic [15:0] hold_timeout_q = HOLD_TIMEOUT_RST;
  logic [7:0]  speed_step_q   = SPEED_STEP_RST;
  logic [7:0]  speed_start_q  = SPEED_START_RST;

  // local copy of the drive state
  logic [7:0]        speed_q  = SPEED_START_RST;
  logic signed [1:0] left_q   = CMD_STOP;
  logic signed [1:0] right_q  = CMD_STOP;
  logic [15:0]       idle_q   = 16'd0;
  logic              halted_q = 1'b0;

  tmd_out_t pending_drive[$];   // expected output words, oldest first
  int       items_sent     = 0;
  int       words_seen     = 0;
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  int       burst_left     = 0;
  int       stall_left     = 0;
  rx_mode_t rx_mode        = RX_OPEN;

  teleop_motor_drive_with_deadman i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // drive model
  // --------------------------------------------------------------------------

  // {duty, pin_b, pin_a} for one bridge
  function automatic logic [12:0] bridge_side(input logic signed [1:0] cmd,
                                              input logic [7:0] speed);
    int duty;
    duty = (int'(speed) * DUTY_RANGE) / 255;
    if (cmd == CMD_FWD) return {duty[10:0], 1'b1, 1'b0};
    else if (cmd == CMD_REV) return {duty[10:0], 1'b0, 1'b1};
    else return 13'd0;
  endfunction

  // advance the model by one input word and build the output word it causes
  function automatic tmd_out_t predict_drive(input logic op, input logic [7:0] key_raw);
    tmd_out_t          w;
    logic [7:0]        k;
    logic [8:0]        raised;
    logic signed [1:0] new_left;
    logic signed [1:0] new_right;
    logic              motion;
    logic              tripped;
    logic [12:0]       side_l;
    logic [12:0]       side_r;
    motion    = 1'b0;
    tripped   = 1'b0;
    new_left  = CMD_STOP;
    new_right = CMD_STOP;
    if (!halted_q) begin
      if (op == OP_TICK) begin
        if (idle_q != IDLE_MAX) idle_q = idle_q + 16'd1;
      end else begin
        k = key_raw;
        if (k >= KEY_UPPER_A && k <= KEY_UPPER_Z) k = k + CASE_OFFSET;
        case (k)
          KEY_ESC: begin
            left_q   = CMD_STOP;
            right_q  = CMD_STOP;
            halted_q = 1'b1;
          end
          KEY_W: begin
            motion = 1'b1; new_left = CMD_FWD; new_right = CMD_FWD;
          end
          KEY_S: begin
            motion = 1'b1; new_left = CMD_REV; new_right = CMD_REV;
          end
          KEY_A: begin
            motion = 1'b1; new_left = CMD_REV; new_right = CMD_FWD;
          end
          KEY_D: begin
            motion = 1'b1; new_left = CMD_FWD; new_right = CMD_REV;
          end
          KEY_Q: begin
            motion = 1'b1; new_left = CMD_STOP; new_right = CMD_FWD;
          end
          KEY_E: begin
            motion = 1'b1; new_left = CMD_FWD; new_right = CMD_STOP;
          end
          KEY_X, KEY_SPACE: begin
            left_q  = CMD_STOP;
            right_q = CMD_STOP;
          end
          KEY_PLUS, KEY_EQUAL: begin
            raised  = {1'b0, speed_q} + {1'b0, speed_step_q};
            speed_q = (raised > {1'b0, SPEED_MAX}) ? SPEED_MAX : raised[7:0];
          end
          KEY_MINUS, KEY_UNDER: begin
            speed_q = (speed_q > speed_step_q) ? speed_q - speed_step_q : 8'd0;
          end
          default: ;
        endcase
        if (motion) begin
          left_q  = new_left;
          right_q = new_right;
          speed_q = speed_start_q;
          idle_q  = 16'd0;
        end
      end
      // dead-man check after every word while running
      if (!halted_q && (left_q != CMD_STOP || right_q != CMD_STOP) &&
          idle_q > hold_timeout_q) begin
        left_q  = CMD_STOP;
        right_q = CMD_STOP;
        tripped = 1'b1;
      end
    end
    side_l          = bridge_side(left_q, speed_q);
    side_r          = bridge_side(right_q, speed_q);
    w.left_pin_a    = side_l[0];
    w.left_pin_b    = side_l[1];
    w.left_duty     = side_l[12:2];
    w.right_pin_a   = side_r[0];
    w.right_pin_b   = side_r[1];
    w.right_duty    = side_r[12:2];
    w.left_command  = left_q;
    w.right_command = right_q;
    w.speed_level   = speed_q;
    w.auto_stopped  = tripped;
    w.halted        = halted_q;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got_v,
                                 input longint unsigned want_v);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch at output word %0d, %s: got 0x%0h, expected 0x%0h",
               words_seen, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [10:0] got_v,
                               input logic [10:0] want_v);
    if (got_v !== want_v) report_mismatch(name, got_v, want_v);
  endtask

  // every accepted output word against the oldest expected one
  always @(posedge clk) begin : check_output
    tmd_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("output word with none pending", m_axis_tdata, 0);
      end else begin
        want = pending_drive.pop_front();
        compare_field("left_pin_a", m_axis_tdata[0], want.left_pin_a);
        compare_field("left_pin_b", m_axis_tdata[1], want.left_pin_b);
        compare_field("left_duty", m_axis_tdata[12:2], want.left_duty);
        compare_field("right_pin_a", m_axis_tdata[13], want.right_pin_a);
        compare_field("right_pin_b", m_axis_tdata[14], want.right_pin_b);
        compare_field("right_duty", m_axis_tdata[25:15], want.right_duty);
        compare_field("left_command", m_axis_tdata[27:26], $unsigned(want.left_command));
        compare_field("right_command", m_axis_tdata[29:28],
                      $unsigned(want.right_command));
        compare_field("speed_level", m_axis_tdata[37:30], want.speed_level);
        compare_field("auto_stopped", m_axis_tdata[38], want.auto_stopped);
        compare_field("halted", m_axis_tdata[39], want.halted);
      end
      words_seen++;
    end
  end

  // receiver: stall pattern is redrawn after a random run length, open runs included
  always @(posedge clk) begin
    if (stall_left == 0) begin
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 400);
    end else begin
      stall_left = stall_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= (stall_left % 8 != 0);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("teleop_motor_drive_with_deadman regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // one input word; valid stays up inside a burst and drops for the gap after it
  task automatic send_word(input logic op, input logic [7:0] key);
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                : $urandom_range(1, 12);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= key;
    do @(posedge clk); while (!s_axis_tready);
    pending_drive.push_back(predict_drive(op, key));
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold off the sender until every expected word is back, then let the pipe settle
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_drive.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_drive.size() != 0) begin
      report_mismatch("output words missing", pending_drive.size(), 0);
      pending_drive.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers plus a write to an unknown index, which must be dropped
  task automatic set_config(input logic [15:0] hold, input logic [15:0] step_raw,
                            input logic [15:0] start_raw);
    logic [7:0]  idx_list [4];
    logic [15:0] val_list [4];
    int          i;
    idx_list[0] = REG_HOLD_TIMEOUT;
    idx_list[1] = REG_SPEED_STEP;
    idx_list[2] = REG_SPEED_START;
    idx_list[3] = 8'($urandom_range(3, 255));
    val_list[0] = hold;
    val_list[1] = step_raw;
    val_list[2] = start_raw;
    val_list[3] = 16'($urandom_range(0, 65535));
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx_list[i])
        REG_HOLD_TIMEOUT: hold_timeout_q = val_list[i];
        REG_SPEED_STEP:   speed_step_q   = val_list[i][7:0];
        REG_SPEED_START:  speed_start_q  = val_list[i][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // one random action: a run of ticks, or a single key of some class
  task automatic send_random_step(input int run_max);
    int         pick;
    int         n;
    logic [7:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(1, run_max);
      repeat (n) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    end else begin
      if (pick < 65) begin
        case ($urandom_range(0, 5))
          0:       k = KEY_W;
          1:       k = KEY_S;
          2:       k = KEY_A;
          3:       k = KEY_D;
          4:       k = KEY_Q;
          default: k = KEY_E;
        endcase
        if ($urandom_range(0, 1) == 1) k = k - CASE_OFFSET;
      end else if (pick < 78) begin
        case ($urandom_range(0, 3))
          0:       k = KEY_PLUS;
          1:       k = KEY_EQUAL;
          2:       k = KEY_MINUS;
          default: k = KEY_UNDER;
        endcase
      end else if (pick < 86) begin
        case ($urandom_range(0, 2))
          0:       k = KEY_SPACE;
          1:       k = KEY_X;
          default: k = KEY_X - CASE_OFFSET;
        endcase
      end else begin
        // any byte but ESC, which would end the run early
        do k = 8'($urandom_range(0, 255)); while (k == KEY_ESC);
      end
      send_word(OP_KEY, k);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every key but ESC at reset settings, case folding and its boundaries
  task automatic test_key_map();
    send_word(OP_TICK, KEY_W);                   // key byte ignored on a tick
    send_word(OP_KEY, KEY_W - CASE_OFFSET);      // upper-case w
    send_word(OP_KEY, KEY_S);
    send_word(OP_KEY, KEY_A);
    send_word(OP_KEY, KEY_D);
    send_word(OP_KEY, KEY_Q);
    send_word(OP_KEY, KEY_E - CASE_OFFSET);
    send_word(OP_KEY, KEY_X);
    send_word(OP_KEY, KEY_A - CASE_OFFSET);
    send_word(OP_KEY, KEY_SPACE);
    send_word(OP_KEY, KEY_PLUS);                 // already at top, saturates
    send_word(OP_KEY, KEY_MINUS);
    send_word(OP_KEY, KEY_UNDER);
    send_word(OP_KEY, KEY_EQUAL);
    send_word(OP_KEY, KEY_D);
    send_word(OP_KEY, KEY_X - CASE_OFFSET);
    send_word(OP_KEY, 8'h00);
    send_word(OP_KEY, 8'hff);
    send_word(OP_KEY, KEY_UPPER_A - 8'd1);       // just below the fold range
    send_word(OP_KEY, KEY_UPPER_Z);              // folds to z, no effect
    send_word(OP_KEY, KEY_UPPER_Z + 8'd1);       // just above the fold range
    send_word(OP_KEY, KEY_Q - CASE_OFFSET);
    send_word(OP_TICK, 8'hff);
  endtask

  // dead-man stop on ticks and on a key after the timeout is lowered
  task automatic test_auto_stop();
    // reset timeout: the tick that passes it stops the drive
    send_word(OP_KEY, KEY_W);
    repeat (int'(HOLD_TIMEOUT_RST) + 2) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    wait_for_drain();
    set_config(16'd0, 16'(SPEED_STEP_RST), 16'(SPEED_START_RST));
    send_word(OP_KEY, KEY_E);                    // idle zero is not past zero
    send_word(OP_TICK, 8'd0);                    // trips
    send_word(OP_TICK, 8'd0);                    // already stopped, no trip
    send_word(OP_KEY, KEY_Q);
    send_word(OP_KEY, KEY_PLUS);
    wait_for_drain();
    set_config(16'd3, 16'(SPEED_STEP_RST), 16'(SPEED_START_RST));
    send_word(OP_KEY, KEY_W);
    repeat (3) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    wait_for_drain();
    // idle count is now above the new timeout, so a plain key trips it
    set_config(16'd1, 16'(SPEED_STEP_RST), 16'(SPEED_START_RST));
    send_word(OP_KEY, KEY_MINUS);
  endtask

  // speed saturation at both ends, register data above the field width
  task automatic test_speed_limits();
    wait_for_drain();
    set_config(IDLE_MAX, 16'd255, 16'd0);
    send_word(OP_KEY, KEY_W);                    // speed restored to zero
    send_word(OP_KEY, KEY_MINUS);                // stays at zero
    send_word(OP_KEY, KEY_PLUS);
    send_word(OP_KEY, KEY_EQUAL);                // saturates at top
    send_word(OP_KEY, KEY_UNDER);
    send_word(OP_KEY, KEY_S);
    wait_for_drain();
    set_config(IDLE_MAX, 16'hff00, 16'hab80);    // step 0, start 0x80
    send_word(OP_KEY, KEY_D);
    send_word(OP_KEY, KEY_PLUS);
    send_word(OP_KEY, KEY_MINUS);
    send_word(OP_KEY, KEY_A);
  endtask

  // idle count equal to the timeout keeps running, one tick more stops
  task automatic test_idle_boundary();
    wait_for_drain();
    set_config(16'(EDGE_HOLD), 16'(SPEED_STEP_RST), 16'(SPEED_START_RST));
    send_word(OP_KEY, KEY_A);
    repeat (EDGE_HOLD) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    send_word(OP_KEY, KEY_PLUS);                 // at the timeout, still moving
    send_word(OP_TICK, 8'd0);                    // trips
    send_word(OP_TICK, 8'd0);
  endtask

  // random phases at several settings, sender held off in the middle of each
  task automatic test_random();
    int          phase;
    int          half;
    int          target;
    int          run_max;
    logic [15:0] hold;
    logic [15:0] step_raw;
    logic [15:0] start_raw;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          hold      = 16'($urandom_range(0, 8));
          step_raw  = 16'($urandom_range(0, 255));
          start_raw = 16'($urandom_range(0, 255));
        end
        1: begin
          hold      = 16'($urandom_range(20, 60));
          step_raw  = 16'($urandom_range(0, 65535));
          start_raw = 16'($urandom_range(0, 65535));
        end
        2: begin
          hold      = IDLE_MAX;
          step_raw  = 16'd0;
          start_raw = 16'd0;
        end
        3: begin
          hold      = 16'd0;
          step_raw  = 16'd255;
          start_raw = 16'd255;
        end
        default: begin
          hold      = 16'($urandom_range(1, 30));
          step_raw  = 16'($urandom_range(1, 20));
          start_raw = 16'($urandom_range(100, 255));
        end
      endcase
      // tick runs long enough to reach the timeout now and then
      run_max = (hold > 16'd60) ? 40 : int'(hold) + int'(hold) / 2 + 4;
      wait_for_drain();
      set_config(hold, step_raw, start_raw);
      half   = items_sent + RANDOM_ITEMS / 10;
      target = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < half) send_random_step(run_max);
      wait_for_drain();
      while (items_sent < target) send_random_step(run_max);
    end
  endtask

  // ESC halts until reset; everything after it shows a stopped, halted drive
  task automatic test_halt();
    int i;
    wait_for_drain();
    set_config(16'd50, 16'd5, 16'd200);
    send_word(OP_KEY, KEY_W);
    send_word(OP_TICK, 8'd0);
    send_word(OP_KEY, KEY_ESC);
    for (i = 0; i < 30; i++) send_random_step(6);
    send_word(OP_KEY, KEY_ESC);
    wait_for_drain();
    set_config(16'd0, 16'd255, 16'd0);
    for (i = 0; i < 30; i++) send_random_step(6);
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_key_map();
    test_auto_stop();
    test_speed_limits();
    test_idle_boundary();
    test_random();
    test_halt();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("teleop_motor_drive_with_deadman regression: pass");
    end else begin
      $display("teleop_motor_drive_with_deadman regression: fail");
    end
    $finish;
  end

endmodule
